// File: src/bqsc_pkg.sv
// bqsc_pkg: widths, codes, command/status types and saturation helpers
// for the smoothed-coefficient biquad filter.
// No dependencies; every other file in src uses it by scoped names.
package bqsc_pkg;

  // field widths
  localparam int SAMPLE_WIDTH = 24;
  localparam int COEF_WIDTH   = 24;
  localparam int DELAY_WIDTH  = SAMPLE_WIDTH + 16;
  localparam int COEF_FRAC    = COEF_WIDTH - 4;

  // shared multiplier: operand a holds a sample or a coefficient difference
  localparam int MUL_A_W = (SAMPLE_WIDTH > COEF_WIDTH) ? SAMPLE_WIDTH : COEF_WIDTH + 1;
  localparam int PROD_W  = MUL_A_W + COEF_WIDTH;
  localparam int RND_W   = PROD_W - COEF_FRAC;
  localparam int SUM_W   = ((DELAY_WIDTH > RND_W) ? DELAY_WIDTH : RND_W) + 2;

  // smoothing step 5243/65536, about 0.08
  localparam int SMOOTH_SHIFT = 16;
  localparam int STEP_W       = PROD_W - SMOOTH_SHIFT;
  localparam logic signed [COEF_WIDTH-1:0] SMOOTH_STEP = COEF_WIDTH'(5243);

  // rounding offsets
  localparam logic signed [PROD_W-1:0] PROD_ROUND  = PROD_W'(1) << (COEF_FRAC - 1);
  localparam logic signed [PROD_W-1:0] SMOOTH_ROUND = PROD_W'(1) << (SMOOTH_SHIFT - 1);

  // coefficient value 1.0
  localparam logic signed [COEF_WIDTH-1:0] COEF_ONE = COEF_WIDTH'(1) << COEF_FRAC;

  // saturation limits on the wide sum
  localparam logic signed [SUM_W-1:0] SAMPLE_MAX =
    {{(SUM_W - SAMPLE_WIDTH + 1){1'b0}}, {(SAMPLE_WIDTH - 1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SAMPLE_MIN = ~SAMPLE_MAX;
  localparam logic signed [SUM_W-1:0] DELAY_MAX =
    {{(SUM_W - DELAY_WIDTH + 1){1'b0}}, {(DELAY_WIDTH - 1){1'b1}}};
  localparam logic signed [SUM_W-1:0] DELAY_MIN = ~DELAY_MAX;

  // item kinds
  typedef enum logic [1:0] {
    KIND_SAMPLE = 2'd0,
    KIND_LOAD   = 2'd1,
    KIND_SMOOTH = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_t;

  // multiplier operand selection
  typedef enum logic [3:0] {
    MUL_X_FF0_IN = 4'd0,
    MUL_X_FF1    = 4'd1,
    MUL_X_FF2    = 4'd2,
    MUL_Y_FB1    = 4'd3,
    MUL_Y_FB2    = 4'd4,
    MUL_SM_FF0   = 4'd5,
    MUL_SM_FF1   = 4'd6,
    MUL_SM_FF2   = 4'd7,
    MUL_SM_FB1   = 4'd8,
    MUL_SM_FB2   = 4'd9
  } mul_op_t;

  // coefficient written by a smoothing step
  typedef enum logic [2:0] {
    CW_NONE = 3'd0,
    CW_FF0  = 3'd1,
    CW_FF1  = 3'd2,
    CW_FF2  = 3'd3,
    CW_FB1  = 3'd4,
    CW_FB2  = 3'd5
  } coef_wr_t;

  // controller to datapath
  typedef struct packed {
    logic     take;
    logic     load_coef;
    logic     clear_delay;
    mul_op_t  mul_op;
    logic     y_step;
    logic     acc1_step;
    logic     acc2_step;
    logic     d1_step;
    logic     d2_step;
    logic     push;
    coef_wr_t coef_wr;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
  } status_t;

  // clamp a wide sum to the sample range
  function automatic logic signed [SAMPLE_WIDTH-1:0] sat_sample(
    input logic signed [SUM_W-1:0] v
  );
    logic signed [SAMPLE_WIDTH-1:0] r;
    if (v > SAMPLE_MAX) begin
      r = SAMPLE_MAX[SAMPLE_WIDTH-1:0];
    end else if (v < SAMPLE_MIN) begin
      r = SAMPLE_MIN[SAMPLE_WIDTH-1:0];
    end else begin
      r = v[SAMPLE_WIDTH-1:0];
    end
    return r;
  endfunction

  function automatic logic sample_clips(input logic signed [SUM_W-1:0] v);
    return (v > SAMPLE_MAX) || (v < SAMPLE_MIN);
  endfunction

  // clamp a wide sum to the delay range
  function automatic logic signed [DELAY_WIDTH-1:0] sat_delay(
    input logic signed [SUM_W-1:0] v
  );
    logic signed [DELAY_WIDTH-1:0] r;
    if (v > DELAY_MAX) begin
      r = DELAY_MAX[DELAY_WIDTH-1:0];
    end else if (v < DELAY_MIN) begin
      r = DELAY_MIN[DELAY_WIDTH-1:0];
    end else begin
      r = v[DELAY_WIDTH-1:0];
    end
    return r;
  endfunction

endpackage

// File: src/bqsc_in_if.sv
// bqsc_in_if: input item channel of the biquad filter (valid/ready + payload)
// Depends on bqsc_pkg for field widths.
interface bqsc_in_if;
  logic                                    valid;
  logic                                    ready;
  logic [1:0]                              kind;
  logic signed [bqsc_pkg::SAMPLE_WIDTH-1:0] sample_in;
  logic signed [bqsc_pkg::COEF_WIDTH-1:0]   target_ff0;
  logic signed [bqsc_pkg::COEF_WIDTH-1:0]   target_ff1;
  logic signed [bqsc_pkg::COEF_WIDTH-1:0]   target_ff2;
  logic signed [bqsc_pkg::COEF_WIDTH-1:0]   target_fb1;
  logic signed [bqsc_pkg::COEF_WIDTH-1:0]   target_fb2;

  modport source (
    output valid, kind, sample_in, target_ff0, target_ff1, target_ff2,
           target_fb1, target_fb2,
    input  ready
  );
  modport sink (
    input  valid, kind, sample_in, target_ff0, target_ff1, target_ff2,
           target_fb1, target_fb2,
    output ready
  );
endinterface

// File: src/bqsc_out_if.sv
// bqsc_out_if: result channel of the biquad filter (valid/ready + payload)
// Depends on bqsc_pkg for field widths.
interface bqsc_out_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [bqsc_pkg::SAMPLE_WIDTH-1:0] sample_out;
  logic                                    clipped;

  modport source (output valid, sample_out, clipped, input ready);
  modport sink (input valid, sample_out, clipped, output ready);
endinterface

// File: src/bqsc_ctrl.sv
// bqsc_ctrl: one-hot sequencer for the biquad filter; issues datapath commands
// Depends on bqsc_pkg (cmd_t, status_t, kind_t, mul_op_t, coef_wr_t).
module bqsc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  input  logic [1:0]         item_kind,
  output logic               item_ready,
  input  bqsc_pkg::status_t  status,
  output bqsc_pkg::cmd_t     cmd
);

  typedef enum logic [12:0] {
    S_IDLE = 13'b0000000000001,
    S_Y    = 13'b0000000000010,
    S_M1   = 13'b0000000000100,
    S_M2   = 13'b0000000001000,
    S_M3   = 13'b0000000010000,
    S_M4   = 13'b0000000100000,
    S_PUSH = 13'b0000001000000,
    S_SM0  = 13'b0000010000000,
    S_SM1  = 13'b0000100000000,
    S_SM2  = 13'b0001000000000,
    S_SM3  = 13'b0010000000000,
    S_SM4  = 13'b0100000000000,
    S_SM5  = 13'b1000000000000
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign item_ready = (state == S_IDLE);
  assign accept     = item_valid & item_ready;

  // next state and commands
  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        cmd.mul_op = bqsc_pkg::MUL_X_FF0_IN;
        cmd.take   = accept;
        if (accept) begin
          case (bqsc_pkg::kind_t'(item_kind))
            bqsc_pkg::KIND_SAMPLE: state_next = S_Y;
            bqsc_pkg::KIND_LOAD:   cmd.load_coef = 1'b1;
            bqsc_pkg::KIND_SMOOTH: state_next = S_SM0;
            bqsc_pkg::KIND_CLEAR:  cmd.clear_delay = 1'b1;
            default:               state_next = S_IDLE;
          endcase
        end
      end
      S_Y: begin
        cmd.y_step = 1'b1;
        cmd.mul_op = bqsc_pkg::MUL_X_FF1;
        state_next = S_M1;
      end
      S_M1: begin
        cmd.acc1_step = 1'b1;
        cmd.mul_op    = bqsc_pkg::MUL_X_FF2;
        state_next    = S_M2;
      end
      S_M2: begin
        cmd.acc2_step = 1'b1;
        cmd.mul_op    = bqsc_pkg::MUL_Y_FB1;
        state_next    = S_M3;
      end
      S_M3: begin
        cmd.d1_step = 1'b1;
        cmd.mul_op  = bqsc_pkg::MUL_Y_FB2;
        state_next  = S_M4;
      end
      S_M4: begin
        cmd.d2_step = 1'b1;
        cmd.push    = status.out_free;
        state_next  = status.out_free ? S_IDLE : S_PUSH;
      end
      S_PUSH: begin
        cmd.push = status.out_free;
        if (status.out_free) begin
          state_next = S_IDLE;
        end
      end
      S_SM0: begin
        cmd.mul_op = bqsc_pkg::MUL_SM_FF0;
        state_next = S_SM1;
      end
      S_SM1: begin
        cmd.mul_op  = bqsc_pkg::MUL_SM_FF1;
        cmd.coef_wr = bqsc_pkg::CW_FF0;
        state_next  = S_SM2;
      end
      S_SM2: begin
        cmd.mul_op  = bqsc_pkg::MUL_SM_FF2;
        cmd.coef_wr = bqsc_pkg::CW_FF1;
        state_next  = S_SM3;
      end
      S_SM3: begin
        cmd.mul_op  = bqsc_pkg::MUL_SM_FB1;
        cmd.coef_wr = bqsc_pkg::CW_FF2;
        state_next  = S_SM4;
      end
      S_SM4: begin
        cmd.mul_op  = bqsc_pkg::MUL_SM_FB2;
        cmd.coef_wr = bqsc_pkg::CW_FB1;
        state_next  = S_SM5;
      end
      S_SM5: begin
        cmd.coef_wr = bqsc_pkg::CW_FB2;
        state_next  = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// File: src/bqsc_datapath.sv
// bqsc_datapath: coefficient and delay registers, shared multiplier,
// rounding/accumulate/saturate logic and the output register.
// Depends on bqsc_pkg; driven by bqsc_ctrl through cmd_t.
module bqsc_datapath (
  input  logic                                    clk,
  input  logic                                    rst,
  input  bqsc_pkg::cmd_t                          cmd,
  output bqsc_pkg::status_t                       status,
  input  logic signed [bqsc_pkg::SAMPLE_WIDTH-1:0] sample_in,
  input  logic signed [bqsc_pkg::COEF_WIDTH-1:0]   target_ff0,
  input  logic signed [bqsc_pkg::COEF_WIDTH-1:0]   target_ff1,
  input  logic signed [bqsc_pkg::COEF_WIDTH-1:0]   target_ff2,
  input  logic signed [bqsc_pkg::COEF_WIDTH-1:0]   target_fb1,
  input  logic signed [bqsc_pkg::COEF_WIDTH-1:0]   target_fb2,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [bqsc_pkg::SAMPLE_WIDTH-1:0] sample_out,
  output logic                                    clipped
);

  localparam int SW = bqsc_pkg::SAMPLE_WIDTH;
  localparam int CW = bqsc_pkg::COEF_WIDTH;
  localparam int DW = bqsc_pkg::DELAY_WIDTH;
  localparam int AW = bqsc_pkg::MUL_A_W;
  localparam int PW = bqsc_pkg::PROD_W;
  localparam int RW = bqsc_pkg::RND_W;
  localparam int UW = bqsc_pkg::SUM_W;
  localparam int TW = bqsc_pkg::STEP_W;

  // sample onto the multiplier's a operand
  function automatic logic signed [AW-1:0] smp_to_a(input logic signed [SW-1:0] v);
    return $signed({{(AW - SW){v[SW-1]}}, v});
  endfunction

  // target minus coefficient onto the a operand
  function automatic logic signed [AW-1:0] diff_to_a(
    input logic signed [CW-1:0] t,
    input logic signed [CW-1:0] c
  );
    logic signed [CW:0] d;
    d = $signed({t[CW-1], t}) - $signed({c[CW-1], c});
    return AW'(d);
  endfunction

  // coefficients and delays
  logic signed [CW-1:0] ff0_coef, ff1_coef, ff2_coef, fb1_coef, fb2_coef;
  logic signed [DW-1:0] delay_one, delay_two;

  // latched item
  logic signed [SW-1:0] x;
  logic signed [CW-1:0] t_ff0, t_ff1, t_ff2, t_fb1, t_fb2;

  // working registers
  logic signed [SW-1:0] y;
  logic                 y_clip;
  logic signed [PW-1:0] prod;
  logic signed [UW-1:0] acc1, acc2;

  logic signed [AW-1:0] a_op;
  logic signed [CW-1:0] b_op;
  logic signed [PW-1:0] rnd_sum, sm_sum;
  logic signed [RW-1:0] rnd;
  logic signed [UW-1:0] rnd_ext, d1_ext, d2_ext;
  logic signed [UW-1:0] y_sum, acc1_sum, d1_sum, d2_sum;
  logic signed [TW-1:0] sm_step;
  logic signed [CW-1:0] sm_cur, sm_new;
  logic signed [TW-1:0] sm_wide;
  logic                 out_free;

  // multiplier operand select
  always_comb begin
    case (cmd.mul_op)
      bqsc_pkg::MUL_X_FF0_IN: begin
        a_op = smp_to_a(sample_in);
        b_op = ff0_coef;
      end
      bqsc_pkg::MUL_X_FF1: begin
        a_op = smp_to_a(x);
        b_op = ff1_coef;
      end
      bqsc_pkg::MUL_X_FF2: begin
        a_op = smp_to_a(x);
        b_op = ff2_coef;
      end
      bqsc_pkg::MUL_Y_FB1: begin
        a_op = smp_to_a(y);
        b_op = fb1_coef;
      end
      bqsc_pkg::MUL_Y_FB2: begin
        a_op = smp_to_a(y);
        b_op = fb2_coef;
      end
      bqsc_pkg::MUL_SM_FF0: begin
        a_op = diff_to_a(t_ff0, ff0_coef);
        b_op = bqsc_pkg::SMOOTH_STEP;
      end
      bqsc_pkg::MUL_SM_FF1: begin
        a_op = diff_to_a(t_ff1, ff1_coef);
        b_op = bqsc_pkg::SMOOTH_STEP;
      end
      bqsc_pkg::MUL_SM_FF2: begin
        a_op = diff_to_a(t_ff2, ff2_coef);
        b_op = bqsc_pkg::SMOOTH_STEP;
      end
      bqsc_pkg::MUL_SM_FB1: begin
        a_op = diff_to_a(t_fb1, fb1_coef);
        b_op = bqsc_pkg::SMOOTH_STEP;
      end
      bqsc_pkg::MUL_SM_FB2: begin
        a_op = diff_to_a(t_fb2, fb2_coef);
        b_op = bqsc_pkg::SMOOTH_STEP;
      end
      default: begin
        a_op = '0;
        b_op = '0;
      end
    endcase
  end

  // rounded product on the sample scale
  assign rnd_sum = prod + bqsc_pkg::PROD_ROUND;
  assign rnd     = $signed(rnd_sum[PW-1:bqsc_pkg::COEF_FRAC]);
  assign rnd_ext = $signed({{(UW - RW){rnd[RW-1]}}, rnd});
  assign d1_ext  = $signed({{(UW - DW){delay_one[DW-1]}}, delay_one});
  assign d2_ext  = $signed({{(UW - DW){delay_two[DW-1]}}, delay_two});

  // recursion sums
  assign y_sum    = rnd_ext + d1_ext;
  assign acc1_sum = rnd_ext + d2_ext;
  assign d1_sum   = acc1 - rnd_ext;
  assign d2_sum   = acc2 - rnd_ext;

  // smoothing step on the coefficient being written
  assign sm_sum  = prod + bqsc_pkg::SMOOTH_ROUND;
  assign sm_step = $signed(sm_sum[PW-1:bqsc_pkg::SMOOTH_SHIFT]);

  always_comb begin
    case (cmd.coef_wr)
      bqsc_pkg::CW_FF0: sm_cur = ff0_coef;
      bqsc_pkg::CW_FF1: sm_cur = ff1_coef;
      bqsc_pkg::CW_FF2: sm_cur = ff2_coef;
      bqsc_pkg::CW_FB1: sm_cur = fb1_coef;
      bqsc_pkg::CW_FB2: sm_cur = fb2_coef;
      default:          sm_cur = '0;
    endcase
  end

  // result stays between old value and target, so truncation is exact
  assign sm_wide = $signed({{(TW - CW){sm_cur[CW-1]}}, sm_cur}) + sm_step;
  assign sm_new  = sm_wide[CW-1:0];

  // coefficient and delay state
  always_ff @(posedge clk) begin
    if (rst) begin
      ff0_coef  <= bqsc_pkg::COEF_ONE;
      ff1_coef  <= '0;
      ff2_coef  <= '0;
      fb1_coef  <= '0;
      fb2_coef  <= '0;
      delay_one <= '0;
      delay_two <= '0;
    end else begin
      if (cmd.load_coef) begin
        ff0_coef <= target_ff0;
        ff1_coef <= target_ff1;
        ff2_coef <= target_ff2;
        fb1_coef <= target_fb1;
        fb2_coef <= target_fb2;
      end else begin
        if (cmd.coef_wr == bqsc_pkg::CW_FF0) ff0_coef <= sm_new;
        if (cmd.coef_wr == bqsc_pkg::CW_FF1) ff1_coef <= sm_new;
        if (cmd.coef_wr == bqsc_pkg::CW_FF2) ff2_coef <= sm_new;
        if (cmd.coef_wr == bqsc_pkg::CW_FB1) fb1_coef <= sm_new;
        if (cmd.coef_wr == bqsc_pkg::CW_FB2) fb2_coef <= sm_new;
      end
      if (cmd.clear_delay) begin
        delay_one <= '0;
        delay_two <= '0;
      end else begin
        if (cmd.d1_step) delay_one <= bqsc_pkg::sat_delay(d1_sum);
        if (cmd.d2_step) delay_two <= bqsc_pkg::sat_delay(d2_sum);
      end
    end
  end

  // item latch, product and accumulators
  always_ff @(posedge clk) begin
    prod <= a_op * b_op;
    if (cmd.take) begin
      x     <= sample_in;
      t_ff0 <= target_ff0;
      t_ff1 <= target_ff1;
      t_ff2 <= target_ff2;
      t_fb1 <= target_fb1;
      t_fb2 <= target_fb2;
    end
    if (cmd.y_step) begin
      y      <= bqsc_pkg::sat_sample(y_sum);
      y_clip <= bqsc_pkg::sample_clips(y_sum);
    end
    if (cmd.acc1_step) acc1 <= acc1_sum;
    if (cmd.acc2_step) acc2 <= rnd_ext;
  end

  // output register
  assign out_free        = ~out_valid | out_ready;
  assign status.out_free = out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      sample_out <= y;
      clipped    <= y_clip;
    end
  end

endmodule

// File: src/biquad_filter_smoothed_coefficients.sv
// biquad_filter_smoothed_coefficients: top level of the biquad filter
// with smoothed coefficient updates; joins bqsc_ctrl and bqsc_datapath.
// Depends on bqsc_pkg, bqsc_in_if, bqsc_out_if.
//
// Usage:
//   item   - valid/ready input channel; kind selects the transaction:
//            sample, coefficient load, coefficient smoothing, delay clear.
//   result - valid/ready output channel; one transaction per sample item,
//            carrying the saturated output and its clip flag.
//   Load and clear items are handled at acceptance, without leaving idle.
//   Items are accepted only while idle, so a sample item runs to its end
//   before the next item is taken: one shared multiplier works through the
//   five products in turn, and the feedback products wait for the saturated
//   output, which enters the output register at the last step. A smoothing
//   item does one multiply per coefficient through the same multiplier.
//   Reset (synchronous, active high) sets ff0 to 1.0 (pass-through), the
//   other coefficients and both delays to zero, and empties the output.
//   If the receiver stalls, the result waits in the output register; the
//   next item is still accepted, and a following sample item holds at its
//   last step until the register frees.
module biquad_filter_smoothed_coefficients (
  input logic        clk,
  input logic        rst,
  bqsc_in_if.sink    item,
  bqsc_out_if.source result
);

  bqsc_pkg::cmd_t    cmd;
  bqsc_pkg::status_t status;

  // sequencer
  bqsc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_kind  (item.kind),
    .item_ready (item.ready),
    .status     (status),
    .cmd        (cmd)
  );

  // arithmetic and state
  bqsc_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .sample_in  (item.sample_in),
    .target_ff0 (item.target_ff0),
    .target_ff1 (item.target_ff1),
    .target_ff2 (item.target_ff2),
    .target_fb1 (item.target_fb1),
    .target_fb2 (item.target_fb2),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .sample_out (result.sample_out),
    .clipped    (result.clipped)
  );

endmodule
